// ===== src/lfe_pkg.sv =====
`default_nettype none
package lfe_pkg;

   localparam int LED_COUNT_DEF = 256;

   localparam int COLOUR_W    = 24;
   localparam int CHAN_W      = 8;
   localparam int REG_W       = 10;
   localparam int BIT_POS_W   = 5;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BIT_POS_W-1:0] TOP_BIT = BIT_POS_W'(COLOUR_W - 1);

   // request kinds carried on req_tuser
   localparam logic [KIND_W-1:0] KIND_SET_ONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET_ALL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RST_SLOTS = 2'd2;

   localparam logic [REG_W-1:0] ONE_HIGH_RST  = 10'd47;
   localparam logic [REG_W-1:0] ZERO_HIGH_RST = 10'd21;
   localparam logic [REG_W-1:0] RST_SLOTS_RST = 10'd113;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_FILL,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CHAN_W-1:0]     led_index;
      logic [COLOUR_W-1:0]   colour;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage
`default_nettype wire

// ===== src/lfe_ram.sv =====
`default_nettype none
module lfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/lfe_front.sv =====
`default_nettype none
module lfe_front #(
   parameter int LED_COUNT = lfe_pkg::LED_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lfe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [lfe_pkg::KIND_W-1:0]          req_tuser,
   input  wire lfe_pkg::back_status_type            status,
   output logic                                     cmd_valid,
   input  wire logic                                cmd_ready,
   output lfe_pkg::cmd_type                         cmd
);
   import lfe_pkg::*;

   logic              hold_valid_ff, hold_valid_in;
   cmd_type           hold_cmd_ff, hold_cmd_in;
   logic [CHAN_W-1:0] led_index;
   logic [COLOUR_W-1:0] colour;
   logic              accept;
   logic              keep;
   cmd_type           cls;

   assign led_index = req_tdata[CHAN_W-1:0];
   // red in the top byte of the colour word, blue in the bottom
   assign colour    = {req_tdata[CHAN_W+:CHAN_W], req_tdata[2*CHAN_W+:CHAN_W],
                       req_tdata[3*CHAN_W+:CHAN_W]};

   assign req_tready = (!hold_valid_ff || cmd_ready) && !status.init_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cls.led_index = led_index;
      cls.colour    = colour;
      cls.op        = OP_TICK;
      keep          = 1'b1;
      case (req_tuser)
         KIND_SET_ONE: begin
            cls.op = OP_WRITE;
            // out-of-range index is dropped here
            keep   = 32'(led_index) < 32'(LED_COUNT);
         end
         KIND_SET_ALL: cls.op = OP_FILL;
         KIND_CLEAR: begin
            cls.op     = OP_FILL;
            cls.colour = '0;
         end
         KIND_TICK:    cls.op = OP_TICK;
         default:      cls.op = OP_TICK;
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff && !cmd_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = keep;
         hold_cmd_in   = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd       = hold_cmd_ff;

endmodule
`default_nettype wire

// ===== src/lfe_queue.sv =====
`default_nettype none
module lfe_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire lfe_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output lfe_pkg::cmd_type      pop_cmd
);
   import lfe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== src/lfe_back.sv =====
`default_nettype none
module lfe_back #(
   parameter int LED_COUNT = lfe_pkg::LED_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   output logic                                   cmd_ready,
   input  wire lfe_pkg::cmd_type                  cmd,
   output lfe_pkg::back_status_type               status,
   input  wire logic                              csr_wen,
   input  wire logic [lfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lfe_pkg::REG_W-1:0]         csr_wdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [lfe_pkg::REG_W-1:0]         rsp_duty,
   output logic                                   rsp_last
);
   import lfe_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [AW-1:0] LAST_LED = AW'(LED_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FILL,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic                 init_ff, init_in;
   logic [AW-1:0]        fill_addr_ff, fill_addr_in;
   logic [COLOUR_W-1:0]  fill_word_ff, fill_word_in;
   logic [AW-1:0]        led_pos_ff, led_pos_in;
   logic [BIT_POS_W-1:0] bit_pos_ff, bit_pos_in;
   logic [REG_W-1:0]     slot_pos_ff, slot_pos_in;
   logic                 in_rst_ff, in_rst_in;
   logic [REG_W-1:0]     one_high_ff, one_high_in;
   logic [REG_W-1:0]     zero_high_ff, zero_high_in;
   logic [REG_W-1:0]     rst_slots_ff, rst_slots_in;
   logic                 out_valid_ff, out_valid_in;
   logic [REG_W-1:0]     out_duty_ff, out_duty_in;
   logic                 out_last_ff, out_last_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [COLOUR_W-1:0]  ram_wdata;
   logic [COLOUR_W-1:0]  ram_rdata;
   logic                 out_free;

   lfe_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (led_pos_ff),
      .rd_data (ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      fill_addr_in = fill_addr_ff;
      fill_word_in = fill_word_ff;
      led_pos_in   = led_pos_ff;
      bit_pos_in   = bit_pos_ff;
      slot_pos_in  = slot_pos_ff;
      in_rst_in    = in_rst_ff;
      one_high_in  = one_high_ff;
      zero_high_in = zero_high_ff;
      rst_slots_in = rst_slots_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_duty_in  = out_duty_ff;
      out_last_in  = out_last_ff;
      cmd_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = AW'(cmd.led_index);
      ram_wdata    = cmd.colour;

      if (csr_wen) begin
         case (csr_index)
            CSR_ONE_HIGH:  one_high_in  = csr_wdata;
            CSR_ZERO_HIGH: zero_high_in = csr_wdata;
            CSR_RST_SLOTS: rst_slots_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_WRITE: begin
                     cmd_ready = 1'b1;
                     ram_we    = 1'b1;
                  end
                  OP_FILL: begin
                     cmd_ready    = 1'b1;
                     fill_word_in = cmd.colour;
                     fill_addr_in = '0;
                     state_in     = S_FILL;
                  end
                  OP_TICK: begin
                     // store read at led_pos_ff is issued this cycle
                     if (out_free) begin
                        cmd_ready = 1'b1;
                        state_in  = S_EMIT;
                     end
                  end
                  default: cmd_ready = 1'b1;
               endcase
            end
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr_ff;
            ram_wdata = fill_word_ff;
            if (fill_addr_ff == LAST_LED) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         S_EMIT: begin
            state_in     = S_IDLE;
            out_valid_in = 1'b1;
            out_last_in  = 1'b0;
            if (in_rst_ff) begin
               out_duty_in = '0;
               if ({1'b0, slot_pos_ff} + 1'b1 >= {1'b0, rst_slots_ff}) begin
                  out_last_in = 1'b1;
                  in_rst_in   = 1'b0;
                  slot_pos_in = '0;
               end else begin
                  slot_pos_in = slot_pos_ff + 1'b1;
               end
            end else begin
               out_duty_in = ram_rdata[bit_pos_ff] ? one_high_ff : zero_high_ff;
               if (bit_pos_ff == '0) begin
                  bit_pos_in = TOP_BIT;
                  if (led_pos_ff == LAST_LED) begin
                     led_pos_in = '0;
                     if (rst_slots_ff == '0) begin
                        out_last_in = 1'b1;
                     end else begin
                        in_rst_in   = 1'b1;
                        slot_pos_in = '0;
                     end
                  end else begin
                     led_pos_in = led_pos_ff + 1'b1;
                  end
               end else begin
                  bit_pos_in = bit_pos_ff - 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset starts a clearing pass over the store
         state_ff     <= S_FILL;
         init_ff      <= 1'b1;
         fill_addr_ff <= '0;
         fill_word_ff <= '0;
         led_pos_ff   <= '0;
         bit_pos_ff   <= TOP_BIT;
         slot_pos_ff  <= '0;
         in_rst_ff    <= 1'b0;
         one_high_ff  <= ONE_HIGH_RST;
         zero_high_ff <= ZERO_HIGH_RST;
         rst_slots_ff <= RST_SLOTS_RST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         fill_addr_ff <= fill_addr_in;
         fill_word_ff <= fill_word_in;
         led_pos_ff   <= led_pos_in;
         bit_pos_ff   <= bit_pos_in;
         slot_pos_ff  <= slot_pos_in;
         in_rst_ff    <= in_rst_in;
         one_high_ff  <= one_high_in;
         zero_high_ff <= zero_high_in;
         rst_slots_ff <= rst_slots_in;
         out_valid_ff <= out_valid_in;
      end
      out_duty_ff <= out_duty_in;
      out_last_ff <= out_last_in;
   end

   assign status.init_busy = init_ff;
   assign rsp_tvalid       = out_valid_ff;
   assign rsp_duty         = out_duty_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

// ===== src/addressable_led_frame_encoder.sv =====
// a tick passes the front hold register and the command queue; the back end reads the store in S_IDLE
//   and selects the compare value in S_EMIT into the output register behind rsp_tvalid, taking no command
//   in S_EMIT; set one LED every cycle in S_IDLE; set all / clear all sweep the store in S_FILL
// a 2-entry command queue lets the request side run ahead of the store sweep
// reset: synchronous, active high; clears the store in an S_FILL sweep, req_tready low meanwhile
`default_nettype none
module addressable_led_frame_encoder #(
   parameter int LED_COUNT = lfe_pkg::LED_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // led_index [7:0], red [15:8], green [23:16], blue [31:24]
   input  wire logic [lfe_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind [1:0]
   input  wire logic [lfe_pkg::KIND_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // duty_value [9:0], zero [15:10]
   output logic      [lfe_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_wen,
   input  wire logic [lfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lfe_pkg::REG_W-1:0]         csr_wdata
);
   import lfe_pkg::*;

   back_status_type  status;
   logic             f_valid, f_ready;
   cmd_type          f_cmd;
   logic             q_valid, q_ready;
   cmd_type          q_cmd;
   logic [REG_W-1:0] duty;

   lfe_front #(.LED_COUNT(LED_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   lfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   lfe_back #(.LED_COUNT(LED_COUNT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .status     (status),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_duty   (duty),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'(duty);

endmodule
`default_nettype wire

// ===== src/lfe_checker.sv =====
`default_nettype none
module lfe_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [lfe_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire logic [lfe_pkg::KIND_W-1:0]        req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [lfe_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tlast,
   input wire logic                              csr_wen,
   input wire logic [lfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input wire logic [lfe_pkg::REG_W-1:0]         csr_wdata
);
   import lfe_pkg::*;

   // a waiting result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // the store clearing pass holds off requests right after reset
   a_init_block: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during clearing pass");

   // a tick needs a store read before its result, so results never come in adjacent cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result loaded without a store read");

   // pad bits above the compare value stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:REG_W] == '0)
      else $error("rsp pad bits set");

endmodule

bind addressable_led_frame_encoder lfe_checker u_lfe_checker (.*);
`default_nettype wire

// ===== verif/tb_addressable_led_frame_encoder.sv =====
`timescale 1ns / 1ps
module tb_addressable_led_frame_encoder;
   import lfe_pkg::*;

   localparam int NUM_LEDS = LED_COUNT_DEF;
   localparam int IDLE_PCT = 38;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // front hold register, two queued fills and the one in the store sweep, then margin
   localparam int SETTLE_CYCLES = 4 * (NUM_LEDS + 1) + 16;

   typedef struct packed {
      logic                   frame_end;
      logic [RSP_TDATA_W-1:0] tdata;
   } slot_t;

   class slot_scoreboard;
      logic [COLOUR_W-1:0] colour_map [NUM_LEDS];
      logic [REG_W-1:0]    one_high;
      logic [REG_W-1:0]    zero_high;
      logic [REG_W-1:0]    reset_len;
      int                  led_pos;
      int                  bit_pos;
      int                  rst_pos;
      bit                  in_rst;
      slot_t               expected_slots [$];
      int                  mismatches;

      function new();
         foreach (colour_map[i]) colour_map[i] = '0;
         one_high   = ONE_HIGH_RST;
         zero_high  = ZERO_HIGH_RST;
         reset_len  = RST_SLOTS_RST;
         led_pos    = 0;
         bit_pos    = COLOUR_W - 1;
         rst_pos    = 0;
         in_rst     = 1'b0;
         mismatches = 0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         case (idx)
            CSR_ONE_HIGH:  one_high = val;
            CSR_ZERO_HIGH: zero_high = val;
            CSR_RST_SLOTS: reset_len = val;
            default: ;
         endcase
      endfunction

      // colour slots still to go before the reset phase of this frame
      function int colour_left();
         if (in_rst) return 0;
         return (NUM_LEDS - 1 - led_pos) * COLOUR_W + bit_pos + 1;
      endfunction

      function slot_t predict_slot();
         slot_t s;
         s = '0;
         if (in_rst) begin
            if (rst_pos + 1 >= reset_len) begin
               s.frame_end = 1'b1;
               in_rst = 1'b0;
               rst_pos = 0;
            end else begin
               rst_pos++;
            end
         end else begin
            s.tdata = {6'b0, colour_map[led_pos][bit_pos] ? one_high : zero_high};
            if (bit_pos == 0) begin
               bit_pos = COLOUR_W - 1;
               if (led_pos == NUM_LEDS - 1) begin
                  led_pos = 0;
                  if (reset_len == 0) begin
                     s.frame_end = 1'b1;
                  end else begin
                     in_rst = 1'b1;
                     rst_pos = 0;
                  end
               end else begin
                  led_pos++;
               end
            end else begin
               bit_pos--;
            end
         end
         return s;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [REQ_TDATA_W-1:0] word);
         logic [COLOUR_W-1:0] rgb;
         rgb = {word[15:8], word[23:16], word[31:24]};
         case (kind)
            KIND_SET_ONE: if (int'(word[7:0]) < NUM_LEDS) colour_map[word[7:0]] = rgb;
            KIND_SET_ALL: foreach (colour_map[i]) colour_map[i] = rgb;
            KIND_CLEAR:   foreach (colour_map[i]) colour_map[i] = '0;
            KIND_TICK:    expected_slots.push_back(predict_slot());
            default: ;
         endcase
      endfunction

      function void check_slot(logic [RSP_TDATA_W-1:0] tdata, logic tlast);
         slot_t want;
         if (expected_slots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected slot, tdata %0d frame_end %0b", $time, tdata, tlast);
            return;
         end
         want = expected_slots.pop_front();
         if (tdata !== want.tdata || tlast !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: slot mismatch, expected tdata %0d frame_end %0b, got %0d %0b",
                        $time, want.tdata, want.frame_end, tdata, tlast);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]      req_tuser = KIND_TICK;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   wire                    rsp_tlast;
   logic                   csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [REG_W-1:0]       csr_wdata = '0;

   bit             idling_on = 1'b1;
   int             hold_req = 0;
   int             hold_left = 0;
   slot_scoreboard sb = new();

   addressable_led_frame_encoder #(.LED_COUNT(NUM_LEDS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_slot(rsp_tdata, rsp_tlast);
   end

   task automatic send_item(logic [KIND_W-1:0] kind, logic [7:0] idx, logic [COLOUR_W-1:0] rgb);
      logic [REQ_TDATA_W-1:0] word;
      word = {rgb[7:0], rgb[15:8], rgb[23:16], idx};
      if (idling_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, word);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(KIND_TICK, 8'($urandom), 24'($urandom));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      sb.apply_reg(idx, val);
   endtask

   task automatic write_regs(logic [REG_W-1:0] one, logic [REG_W-1:0] zero,
                             logic [REG_W-1:0] slots);
      write_reg(CSR_ONE_HIGH, one);
      write_reg(CSR_ZERO_HIGH, zero);
      write_reg(CSR_RST_SLOTS, slots);
      write_reg(CSR_SPARE, 10'($urandom));
   endtask

   // drain all ticks, then let any pending store sweep finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // tick through the frame, rewriting LEDs just ahead of the send position
   task automatic walk_frame(int left);
      while (sb.colour_left() > left) begin
         if ($urandom_range(99) < 8)
            send_item(KIND_SET_ONE, 8'(sb.led_pos + $urandom_range(2)), 24'($urandom));
         else
            send_ticks(1);
      end
   endtask

   task automatic random_item();
      int                  r;
      logic [COLOUR_W-1:0] rgb;
      logic [7:0]          idx;
      r = $urandom_range(99);
      rgb = 24'($urandom);
      if ($urandom_range(9) == 0) rgb = '0;
      else if ($urandom_range(9) == 0) rgb = '1;
      idx = $urandom_range(1) ? 8'(sb.led_pos + $urandom_range(1)) : 8'($urandom);
      if (r < 55) send_ticks(1);
      else if (r < 94) send_item(KIND_SET_ONE, idx, rgb);
      else if (r < 97) send_item(KIND_SET_ALL, idx, rgb);
      else send_item(KIND_CLEAR, idx, rgb);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values, field extremes and every kind
      send_item(KIND_SET_ONE, 8'd0, 24'hFF00FF);
      send_item(KIND_SET_ONE, 8'd255, 24'h00FF00);
      send_ticks(4);
      send_item(KIND_SET_ALL, 8'd255, 24'h5AC3A5);
      send_ticks(4);
      send_item(KIND_CLEAR, 8'hFF, 24'hFFFFFF);
      send_ticks(3);
      send_item(KIND_SET_ONE, 8'd0, 24'hFFFFFF);
      send_ticks(2);
      send_item(KIND_SET_ONE, 8'd128, 24'h000000);
      send_item(KIND_SET_ONE, 8'd1, 24'h800001);
      send_ticks(2);

      // no reset slots: the last colour bit ends the frame; no idling here
      settle();
      write_regs(10'd1023, 10'd0, 10'd0);
      idling_on = 1'b0;
      walk_frame(1);
      send_ticks(4);
      idling_on = 1'b1;

      // a single reset slot
      settle();
      write_regs(10'd512, 10'd1, 10'd1);
      walk_frame(1);
      send_ticks(3);

      // longest reset phase, cut short to the current slot
      settle();
      write_regs(10'd0, 10'd1023, 10'd1023);
      walk_frame(1);
      send_ticks(21);
      settle();
      write_reg(CSR_RST_SLOTS, 10'd20);
      send_ticks(2);

      // reset phase cut by a write of zero
      settle();
      write_regs(10'd1, 10'd1022, 10'd40);
      walk_frame(1);
      send_ticks(11);
      settle();
      write_reg(CSR_RST_SLOTS, 10'd0);
      send_ticks(3);

      for (int p = 0; p < 4; p++) begin
         settle();
         write_regs(10'($urandom), 10'($urandom), 10'($urandom_range(1023)));
         for (int n = 0; n < 412; n++) begin
            // receiver stops for a while so the request side backs up
            if (p == 1 && n == 100) hold_req = 400;
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      while (sb.expected_slots.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb_addressable_led_frame_encoder: done, clean");
      else
         $display("tb_addressable_led_frame_encoder: done, errors");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb_addressable_led_frame_encoder: done, errors");
      $finish;
   end

endmodule

// ===== addressable_led_frame_encoder.f =====
src/lfe_pkg.sv
src/lfe_ram.sv
src/lfe_front.sv
src/lfe_queue.sv
src/lfe_back.sv
src/addressable_led_frame_encoder.sv
src/lfe_checker.sv
verif/tb_addressable_led_frame_encoder.sv
